// ----- rtl/lkpc_pkg.sv -----
// ----------------------------------------------------------------------------
// lkpc_pkg
// Shared types and constants for the ladder keypad press classifier.
// ----------------------------------------------------------------------------
package lkpc_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int TIME_W     = 32;
    localparam int TIMEOUT_W  = 16;
    localparam int DEBOUNCE_W = 10;
    localparam int KEY_W      = 3;
    localparam int MAX_KEYS   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 8;

    localparam logic [SAMPLE_W-1:0] NO_KEY_LEVEL = 10'd1023;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_KEY0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_KEY1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_KEY2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_KEY3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_KEY4    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_TIMEOUT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_INTERVAL = 3'd6;

    localparam logic [SAMPLE_W-1:0]   RST_THRESHOLD_KEY0    = 10'd50;
    localparam logic [SAMPLE_W-1:0]   RST_THRESHOLD_KEY1    = 10'd200;
    localparam logic [SAMPLE_W-1:0]   RST_THRESHOLD_KEY2    = 10'd400;
    localparam logic [SAMPLE_W-1:0]   RST_THRESHOLD_KEY3    = 10'd600;
    localparam logic [SAMPLE_W-1:0]   RST_THRESHOLD_KEY4    = 10'd800;
    localparam logic [TIMEOUT_W-1:0]  RST_PRESS_TIMEOUT     = 16'd1000;
    localparam logic [DEBOUNCE_W-1:0] RST_DEBOUNCE_INTERVAL = 10'd50;

    typedef enum logic [1:0] {
        PH_OFF     = 2'd0,
        PH_PENDING = 2'd1,
        PH_ON      = 2'd2,
        PH_LONG    = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        EV_CLICK    = 2'd0,
        EV_LONG     = 2'd1,
        EV_TWO_KEY  = 2'd2
    } event_kind_t;

    typedef struct packed {
        logic [MAX_KEYS-1:0][SAMPLE_W-1:0] threshold;
        logic [TIMEOUT_W-1:0]              press_timeout;
        logic [DEBOUNCE_W-1:0]             debounce_interval;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]   now_ms;
        logic [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic [KEY_W-1:0] other_key;
        logic [KEY_W-1:0] key;
        event_kind_t      event_kind;
    } result_t;

endpackage

// ----- rtl/ladder_keypad_press_classifier.sv -----
// ----------------------------------------------------------------------------
// ladder_keypad_press_classifier
// Classifies clicks, long presses and two-key presses of a resistor-ladder
// keypad from timestamped ADC samples.
// ----------------------------------------------------------------------------
// A request is held in the input register, and its result in the output register.
// Throughput: one request per cycle while the output register can take a result.
// A request can still enter an empty input register while a result waits downstream.
// Reset is synchronous and active low; it restores the control and config
// registers to their defaults and clears every key, with no clearing pass.
// ----------------------------------------------------------------------------
module ladder_keypad_press_classifier #(
    parameter int NUM_KEYS = 5
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: now_ms[31:0], sample[41:32], zero padding.
    input  logic [lkpc_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: event_kind[1:0], key[4:2], other_key[7:5].
    output logic [lkpc_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [lkpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lkpc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    lkpc_pkg::cfg_t    cfg;
    lkpc_pkg::item_t   s_item;
    lkpc_pkg::item_t   item;
    lkpc_pkg::result_t result;
    lkpc_pkg::result_t m_result;
    logic              item_valid;
    logic              can_load;
    logic              fire;
    logic              emit;

    assign s_item.now_ms = s_tdata[lkpc_pkg::TIME_W-1:0];
    assign s_item.sample = s_tdata[lkpc_pkg::TIME_W+lkpc_pkg::SAMPLE_W-1:lkpc_pkg::TIME_W];
    assign fire          = item_valid && can_load;
    assign m_tdata       = m_result;

    lkpc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lkpc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (fire)
    );

    lkpc_core #(
        .NUM_KEYS (NUM_KEYS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .fire    (fire),
        .item    (item),
        .emit    (emit),
        .result  (result)
    );

    lkpc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .emit     (emit),
        .result   (result),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (m_result),
        .can_load (can_load)
    );

endmodule

// ----- rtl/lkpc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lkpc_cfg_regs
// Configuration register file: thresholds, press timeout and debounce interval.
// ----------------------------------------------------------------------------
module lkpc_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [lkpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lkpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output lkpc_pkg::cfg_t                      cfg
);

    lkpc_pkg::cfg_t cfg_reg;
    lkpc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                lkpc_pkg::REG_THRESHOLD_KEY0:
                    cfg_next.threshold[0] = cfg_wdata[lkpc_pkg::SAMPLE_W-1:0];
                lkpc_pkg::REG_THRESHOLD_KEY1:
                    cfg_next.threshold[1] = cfg_wdata[lkpc_pkg::SAMPLE_W-1:0];
                lkpc_pkg::REG_THRESHOLD_KEY2:
                    cfg_next.threshold[2] = cfg_wdata[lkpc_pkg::SAMPLE_W-1:0];
                lkpc_pkg::REG_THRESHOLD_KEY3:
                    cfg_next.threshold[3] = cfg_wdata[lkpc_pkg::SAMPLE_W-1:0];
                lkpc_pkg::REG_THRESHOLD_KEY4:
                    cfg_next.threshold[4] = cfg_wdata[lkpc_pkg::SAMPLE_W-1:0];
                lkpc_pkg::REG_PRESS_TIMEOUT:
                    cfg_next.press_timeout = cfg_wdata[lkpc_pkg::TIMEOUT_W-1:0];
                lkpc_pkg::REG_DEBOUNCE_INTERVAL:
                    cfg_next.debounce_interval = cfg_wdata[lkpc_pkg::DEBOUNCE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold[0]      <= lkpc_pkg::RST_THRESHOLD_KEY0;
            cfg_reg.threshold[1]      <= lkpc_pkg::RST_THRESHOLD_KEY1;
            cfg_reg.threshold[2]      <= lkpc_pkg::RST_THRESHOLD_KEY2;
            cfg_reg.threshold[3]      <= lkpc_pkg::RST_THRESHOLD_KEY3;
            cfg_reg.threshold[4]      <= lkpc_pkg::RST_THRESHOLD_KEY4;
            cfg_reg.press_timeout     <= lkpc_pkg::RST_PRESS_TIMEOUT;
            cfg_reg.debounce_interval <= lkpc_pkg::RST_DEBOUNCE_INTERVAL;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/lkpc_in_stage.sv -----
// ----------------------------------------------------------------------------
// lkpc_in_stage
// Input register holding one timestamped sample until the core takes it.
// ----------------------------------------------------------------------------
module lkpc_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lkpc_pkg::item_t     s_item,
    output logic                item_valid,
    output lkpc_pkg::item_t     item,
    input  logic                item_take
);

    logic            valid_reg;
    logic            valid_next;
    lkpc_pkg::item_t item_reg;

    assign s_ready = !valid_reg || item_take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/lkpc_core.sv -----
// ----------------------------------------------------------------------------
// lkpc_core
// Key state, debounce timing and press classification for one sample a cycle while fire is high.
// ----------------------------------------------------------------------------
module lkpc_core #(
    parameter int NUM_KEYS = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lkpc_pkg::cfg_t      cfg,
    input  logic                fire,
    input  lkpc_pkg::item_t     item,
    output logic                emit,
    output lkpc_pkg::result_t   result
);

    lkpc_pkg::phase_t                   phase_reg [NUM_KEYS];
    lkpc_pkg::phase_t                   phase_next [NUM_KEYS];
    logic                               reported_reg;
    logic                               reported_next;
    logic [lkpc_pkg::TIME_W-1:0]        change_time_reg;
    logic [lkpc_pkg::TIME_W-1:0]        change_time_next;
    logic [lkpc_pkg::SAMPLE_W-1:0]      prev_sample_reg;
    logic [lkpc_pkg::SAMPLE_W-1:0]      prev_sample_next;

    always_comb begin
        logic [lkpc_pkg::TIME_W-1:0] elapsed;
        logic                        settled;
        logic                        hit;
        logic [lkpc_pkg::KEY_W-1:0]  sel;
        lkpc_pkg::phase_t            cur;
        lkpc_pkg::phase_t            upd;
        logic                        other_hit;
        logic [lkpc_pkg::KEY_W-1:0]  other;
        logic                        on_hit;
        logic [lkpc_pkg::KEY_W-1:0]  on_key;

        elapsed = item.now_ms - change_time_reg;
        settled = elapsed >= {{(lkpc_pkg::TIME_W-lkpc_pkg::DEBOUNCE_W){1'b0}},
                              cfg.debounce_interval};

        hit = 1'b0;
        sel = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--) begin
            if (item.sample < cfg.threshold[i]) begin
                hit = 1'b1;
                sel = lkpc_pkg::KEY_W'(i);
            end
        end

        cur = lkpc_pkg::PH_OFF;
        for (int i = 0; i < NUM_KEYS; i++) begin
            if (sel == lkpc_pkg::KEY_W'(i)) begin
                cur = phase_reg[i];
            end
        end

        other_hit = 1'b0;
        other     = '0;
        on_hit    = 1'b0;
        on_key    = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--) begin
            if (phase_reg[i] == lkpc_pkg::PH_ON) begin
                on_hit = 1'b1;
                on_key = lkpc_pkg::KEY_W'(i);
                if (sel != lkpc_pkg::KEY_W'(i)) begin
                    other_hit = 1'b1;
                    other     = lkpc_pkg::KEY_W'(i);
                end
            end
        end

        for (int i = 0; i < NUM_KEYS; i++) begin
            phase_next[i] = phase_reg[i];
        end
        reported_next    = reported_reg;
        change_time_next = change_time_reg;
        prev_sample_next = prev_sample_reg;
        emit             = 1'b0;
        result.event_kind = lkpc_pkg::EV_CLICK;
        result.key        = '0;
        result.other_key  = '0;
        upd               = cur;

        if (fire && settled) begin
            if (item.sample != lkpc_pkg::NO_KEY_LEVEL) begin
                if (!reported_reg && hit) begin
                    unique case (cur)
                        lkpc_pkg::PH_OFF: begin
                            upd              = lkpc_pkg::PH_PENDING;
                            change_time_next = item.now_ms;
                        end
                        lkpc_pkg::PH_PENDING: begin
                            upd              = lkpc_pkg::PH_ON;
                            change_time_next = item.now_ms;
                        end
                        lkpc_pkg::PH_ON: begin
                            if (elapsed > {{(lkpc_pkg::TIME_W-lkpc_pkg::TIMEOUT_W){1'b0}},
                                           cfg.press_timeout}) begin
                                upd              = lkpc_pkg::PH_LONG;
                                change_time_next = item.now_ms;
                            end
                        end
                        default: begin
                        end
                    endcase
                    for (int i = 0; i < NUM_KEYS; i++) begin
                        if (sel == lkpc_pkg::KEY_W'(i)) begin
                            phase_next[i] = upd;
                        end
                    end
                    if (upd == lkpc_pkg::PH_LONG) begin
                        emit              = 1'b1;
                        result.event_kind = other_hit ? lkpc_pkg::EV_TWO_KEY
                                                      : lkpc_pkg::EV_LONG;
                        result.key        = sel;
                        result.other_key  = other_hit ? other : '0;
                        reported_next     = 1'b1;
                    end
                    prev_sample_next = item.sample;
                end
            end else begin
                if (prev_sample_reg != lkpc_pkg::NO_KEY_LEVEL) begin
                    if (!reported_reg && on_hit) begin
                        emit              = 1'b1;
                        result.event_kind = lkpc_pkg::EV_CLICK;
                        result.key        = on_key;
                    end
                    for (int i = 0; i < NUM_KEYS; i++) begin
                        phase_next[i] = lkpc_pkg::PH_OFF;
                    end
                    reported_next    = 1'b0;
                    change_time_next = '0;
                end
                prev_sample_next = item.sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_KEYS; i++) begin
                phase_reg[i] <= lkpc_pkg::PH_OFF;
            end
            reported_reg    <= 1'b0;
            change_time_reg <= '0;
            prev_sample_reg <= lkpc_pkg::NO_KEY_LEVEL;
        end else begin
            for (int i = 0; i < NUM_KEYS; i++) begin
                phase_reg[i] <= phase_next[i];
            end
            reported_reg    <= reported_next;
            change_time_reg <= change_time_next;
            prev_sample_reg <= prev_sample_next;
        end
    end

endmodule

// ----- rtl/lkpc_out_stage.sv -----
// ----------------------------------------------------------------------------
// lkpc_out_stage
// Result register that holds a press event until the downstream side takes it.
// ----------------------------------------------------------------------------
module lkpc_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  logic                emit,
    input  lkpc_pkg::result_t   result,
    output logic                m_valid,
    input  logic                m_ready,
    output lkpc_pkg::result_t   m_result,
    output logic                can_load
);

    logic              valid_reg;
    logic              valid_next;
    lkpc_pkg::result_t result_reg;

    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (fire) begin
            valid_next = emit;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

// ----- rtl/lkpc_checker.sv -----
// ----------------------------------------------------------------------------
// lkpc_checker
// Port-level checks on the result channel of the keypad press classifier.
// ----------------------------------------------------------------------------
module lkpc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [lkpc_pkg::M_TDATA_W-1:0]   m_tdata
);

    a_out_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3 && m_tdata[4:2] <= 3'd4)
        else $error("illegal event kind or key");

    a_other_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == 2'd2) ? (m_tdata[7:5] != m_tdata[4:2])
                                            : (m_tdata[7:5] == 3'd0))
        else $error("second key inconsistent with event kind");

endmodule

bind ladder_keypad_press_classifier lkpc_checker u_lkpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
